// File: hdl/lbps_pkg.sv
package lbps_pkg;

    // mode codes as seen on the active_mode field
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_CHASE = 2'd1,
        MODE_PAIRS = 2'd2,
        MODE_ALL   = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LED_ON_TIME        = 3'd0,
        REG_LED_OFF_TIME       = 3'd1,
        REG_START_BEEP_ENABLE  = 3'd2,
        REG_START_BEEP_TIME    = 3'd3,
        REG_PAIR_BEEP_ON_TIME  = 3'd4,
        REG_PAIR_BEEP_OFF_TIME = 3'd5,
        REG_ALL_BEEP_ON_TIME   = 3'd6,
        REG_ALL_BEEP_OFF_TIME  = 3'd7
    } reg_idx_t;

    localparam int TIME_W  = 32;
    localparam int MODE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int LED_N   = 4;
    localparam int INDEX_W = 3;

    // requests at or above this count as idle
    localparam logic [MODE_W-1:0] MODE_COUNT = 8'd4;

    localparam logic [LED_N-1:0] ALL_LEDS  = 4'hF;
    localparam logic [LED_N-1:0] PAIR_LOW  = 4'h3;
    localparam logic [LED_N-1:0] PAIR_HIGH = 4'hC;

    // reset values of the configuration registers
    localparam logic [LEN_W-1:0] RST_LED_ON_TIME        = 16'd250;
    localparam logic [LEN_W-1:0] RST_LED_OFF_TIME       = 16'd250;
    localparam logic             RST_START_BEEP_ENABLE  = 1'b0;
    localparam logic [LEN_W-1:0] RST_START_BEEP_TIME    = 16'd0;
    localparam logic [LEN_W-1:0] RST_PAIR_BEEP_ON_TIME  = 16'd200;
    localparam logic [LEN_W-1:0] RST_PAIR_BEEP_OFF_TIME = 16'd800;
    localparam logic [LEN_W-1:0] RST_ALL_BEEP_ON_TIME   = 16'd50;
    localparam logic [LEN_W-1:0] RST_ALL_BEEP_OFF_TIME  = 16'd100;

    typedef struct packed {
        logic [LEN_W-1:0] led_on_time;
        logic [LEN_W-1:0] led_off_time;
        logic             start_beep_enable;
        logic [LEN_W-1:0] start_beep_time;
        logic [LEN_W-1:0] pair_beep_on_time;
        logic [LEN_W-1:0] pair_beep_off_time;
        logic [LEN_W-1:0] all_beep_on_time;
        logic [LEN_W-1:0] all_beep_off_time;
    } cfg_t;

    typedef struct packed {
        logic [LED_N-1:0] led_levels;
        logic             buzzer_level;
        mode_t            active_mode;
    } result_t;

    // one-shot timer check, elapsed time taken modulo 2^32
    function automatic logic timer_done(
        input logic              running,
        input logic [TIME_W-1:0] start,
        input logic [LEN_W-1:0]  length,
        input logic [TIME_W-1:0] now
    );
        logic [TIME_W-1:0] elapsed;
        elapsed = now - start;
        return running && (elapsed >= {{(TIME_W-LEN_W){1'b0}}, length});
    endfunction

    // LED group lit in the given mode and step
    function automatic logic [LED_N-1:0] pattern_bits(
        input mode_t      mode,
        input logic [1:0] step
    );
        logic [LED_N-1:0] bits;
        case (mode)
            MODE_CHASE: bits = 4'b0001 << step;
            MODE_PAIRS: bits = (step == 2'd0) ? PAIR_LOW : PAIR_HIGH;
            MODE_ALL:   bits = ALL_LEDS;
            default:    bits = '0;
        endcase
        return bits;
    endfunction

endpackage

// File: hdl/lbps_ifs.sv
interface lbps_req_if;
    logic                              valid;
    logic                              ready;
    logic [lbps_pkg::TIME_W-1:0]       time_ms;
    logic [lbps_pkg::MODE_W-1:0]       mode_request;

    modport source (output valid, output time_ms, output mode_request, input ready);
    modport sink   (input valid, input time_ms, input mode_request, output ready);
endinterface

interface lbps_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [lbps_pkg::LED_N-1:0]        led_levels;
    logic                              buzzer_level;
    logic [1:0]                        active_mode;

    modport source (output valid, output led_levels, output buzzer_level,
                    output active_mode, input ready);
    modport sink   (input valid, input led_levels, input buzzer_level,
                    input active_mode, output ready);
endinterface

interface lbps_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lbps_pkg::INDEX_W-1:0]      index;
    logic [lbps_pkg::LEN_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/led_buzzer_pattern_sequencer.sv
// LED and buzzer pattern sequencer
// req carries one item per millisecond tick or poll: time_ms and mode_request.
// rsp returns one item per request: led_levels, buzzer_level and active_mode.
// cfg writes the eight configuration registers by index and is always ready.
// It is to be used only while no request is in flight; this is not enforced.
// An accepted request is held in the input register; the step logic
// (two 32-bit elapsed-time compares and small updates) then loads the sequencer
// state and the output register together, from which the result shows on rsp.
// Throughput is one item per cycle while rsp is ready. While rsp is stalled the
// output register holds its item, the input register can still take one more
// request, and req ready drops only when both are full.
// Reset clears both registers' valid bits and the sequencer state (idle mode,
// LEDs and buzzer off, timers stopped) and loads the register reset values.
module led_buzzer_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    lbps_req_if.sink    req,
    lbps_rsp_if.source  rsp,
    lbps_cfg_if.sink    cfg
);

    lbps_pkg::cfg_t                  regs;
    lbps_pkg::result_t               result;

    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic [lbps_pkg::TIME_W-1:0]     time_reg;
    logic [lbps_pkg::MODE_W-1:0]     mode_req_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    lbps_pkg::result_t               out_reg;
    logic                            step_en;
    logic                            req_fire;

    lbps_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lbps_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .time_ms      (time_reg),
        .mode_request (mode_req_reg),
        .regs         (regs),
        .result       (result)
    );

    // pipeline handshake
    assign step_en   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || step_en;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        in_valid_next  = req_fire || (in_valid_reg && !step_en);
        out_valid_next = step_en || (out_valid_reg && !rsp.ready);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            time_reg     <= req.time_ms;
            mode_req_reg <= req.mode_request;
        end
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.led_levels   = out_reg.led_levels;
    assign rsp.buzzer_level = out_reg.buzzer_level;
    assign rsp.active_mode  = out_reg.active_mode;

endmodule

// File: hdl/lbps_cfg_regs.sv
module lbps_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    lbps_cfg_if.sink        cfg,
    output lbps_pkg::cfg_t  regs
);

    lbps_pkg::cfg_t regs_reg;
    lbps_pkg::cfg_t regs_next;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (lbps_pkg::reg_idx_t'(cfg.index))
                lbps_pkg::REG_LED_ON_TIME:        regs_next.led_on_time        = cfg.data;
                lbps_pkg::REG_LED_OFF_TIME:       regs_next.led_off_time       = cfg.data;
                lbps_pkg::REG_START_BEEP_ENABLE:  regs_next.start_beep_enable  = cfg.data[0];
                lbps_pkg::REG_START_BEEP_TIME:    regs_next.start_beep_time    = cfg.data;
                lbps_pkg::REG_PAIR_BEEP_ON_TIME:  regs_next.pair_beep_on_time  = cfg.data;
                lbps_pkg::REG_PAIR_BEEP_OFF_TIME: regs_next.pair_beep_off_time = cfg.data;
                lbps_pkg::REG_ALL_BEEP_ON_TIME:   regs_next.all_beep_on_time   = cfg.data;
                lbps_pkg::REG_ALL_BEEP_OFF_TIME:  regs_next.all_beep_off_time  = cfg.data;
                default:                          regs_next = regs_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.led_on_time        <= lbps_pkg::RST_LED_ON_TIME;
            regs_reg.led_off_time       <= lbps_pkg::RST_LED_OFF_TIME;
            regs_reg.start_beep_enable  <= lbps_pkg::RST_START_BEEP_ENABLE;
            regs_reg.start_beep_time    <= lbps_pkg::RST_START_BEEP_TIME;
            regs_reg.pair_beep_on_time  <= lbps_pkg::RST_PAIR_BEEP_ON_TIME;
            regs_reg.pair_beep_off_time <= lbps_pkg::RST_PAIR_BEEP_OFF_TIME;
            regs_reg.all_beep_on_time   <= lbps_pkg::RST_ALL_BEEP_ON_TIME;
            regs_reg.all_beep_off_time  <= lbps_pkg::RST_ALL_BEEP_OFF_TIME;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// File: hdl/lbps_core.sv
module lbps_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [lbps_pkg::TIME_W-1:0]   time_ms,
    input  logic [lbps_pkg::MODE_W-1:0]   mode_request,
    input  lbps_pkg::cfg_t                regs,
    output lbps_pkg::result_t             result
);

    typedef struct packed {
        lbps_pkg::mode_t                mode;
        logic                           started;
        logic [1:0]                     step;
        logic                           lit;
        logic                           beep;
        logic [lbps_pkg::LED_N-1:0]     pins;
        logic [lbps_pkg::TIME_W-1:0]    lt_start;
        logic [lbps_pkg::LEN_W-1:0]     lt_len;
        logic                           lt_run;
        logic [lbps_pkg::TIME_W-1:0]    bt_start;
        logic [lbps_pkg::LEN_W-1:0]     bt_len;
        logic                           bt_run;
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;

    // one step of the sequencer on the held item
    always_comb
    begin
        seq_state_t                  s;
        lbps_pkg::mode_t             req;
        logic [lbps_pkg::LEN_W-1:0]  beep_on;
        logic [lbps_pkg::LEN_W-1:0]  beep_off;

        s = state_reg;

        // out-of-range requests fold to idle
        if (mode_request >= lbps_pkg::MODE_COUNT)
            req = lbps_pkg::MODE_OFF;
        else
            req = lbps_pkg::mode_t'(mode_request[1:0]);

        beep_on  = (s.mode == lbps_pkg::MODE_ALL) ? regs.all_beep_on_time
                                                  : regs.pair_beep_on_time;
        beep_off = (s.mode == lbps_pkg::MODE_ALL) ? regs.all_beep_off_time
                                                  : regs.pair_beep_off_time;

        if (!s.started || req != s.mode)
        begin
            // mode entry: clear outputs, stop timers, arm fresh
            s.pins   = '0;
            s.beep   = 1'b0;
            s.lit    = 1'b0;
            s.lt_run = 1'b0;
            s.bt_run = 1'b0;
            s.mode   = req;
            if (req != lbps_pkg::MODE_OFF)
            begin
                s.lit      = 1'b1;
                s.lt_start = time_ms;
                s.lt_len   = regs.led_on_time;
                s.lt_run   = 1'b1;
            end
            if (regs.start_beep_enable)
            begin
                s.beep     = 1'b1;
                s.bt_start = time_ms;
                s.bt_len   = regs.start_beep_time;
                s.bt_run   = 1'b1;
            end
            s.started = 1'b1;
        end
        else if (s.mode != lbps_pkg::MODE_OFF)
        begin
            // pairs mode only knows two steps
            if (s.mode == lbps_pkg::MODE_PAIRS && s.step > 2'd1)
                s.step = 2'd0;

            // LED pattern
            if (s.lit)
                s.pins = s.pins | lbps_pkg::pattern_bits(s.mode, s.step);
            if (lbps_pkg::timer_done(s.lt_run, s.lt_start, s.lt_len, time_ms))
            begin
                s.lt_run = 1'b0;
                if (s.lit)
                begin
                    s.pins     = s.pins & ~lbps_pkg::pattern_bits(s.mode, s.step);
                    s.lit      = 1'b0;
                    s.lt_start = time_ms;
                    s.lt_len   = regs.led_off_time;
                    s.lt_run   = 1'b1;
                end
                else
                begin
                    case (s.mode)
                        lbps_pkg::MODE_CHASE: s.step = s.step + 2'd1;
                        lbps_pkg::MODE_PAIRS: s.step = (s.step == 2'd0) ? 2'd1 : 2'd0;
                        default:              s.step = s.step;
                    endcase
                    s.pins     = s.pins | lbps_pkg::pattern_bits(s.mode, s.step);
                    s.lit      = 1'b1;
                    s.lt_start = time_ms;
                    s.lt_len   = regs.led_on_time;
                    s.lt_run   = 1'b1;
                end
            end

            // buzzer rhythm, pairs and all modes
            if (s.mode != lbps_pkg::MODE_CHASE)
            begin
                if (!s.bt_run && !s.beep)
                begin
                    s.beep     = 1'b1;
                    s.bt_start = time_ms;
                    s.bt_len   = beep_on;
                    s.bt_run   = 1'b1;
                end
                if (lbps_pkg::timer_done(s.bt_run, s.bt_start, s.bt_len, time_ms))
                begin
                    s.bt_start = time_ms;
                    s.bt_run   = 1'b1;
                    if (s.beep)
                    begin
                        s.beep   = 1'b0;
                        s.bt_len = beep_off;
                    end
                    else
                    begin
                        s.beep   = 1'b1;
                        s.bt_len = beep_on;
                    end
                end
            end
        end

        state_next = step_en ? s : state_reg;
    end

    // result of the step, taken by the output register
    assign result.led_levels   = state_next.pins;
    assign result.buzzer_level = state_next.beep;
    assign result.active_mode  = state_next.mode;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: lbps_pkg::MODE_OFF, default: '0};
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/lbps_checker.sv
module lbps_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [lbps_pkg::LED_N-1:0]  led_levels,
    input  logic [1:0]                  active_mode
);

    // a stalled item stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp item dropped while stalled");

    // idle mode keeps every LED dark
    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && active_mode == lbps_pkg::MODE_OFF |-> led_levels == '0)
        else $error("LED lit in idle mode");

    // chase lights at most one LED
    a_chase_one: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && active_mode == lbps_pkg::MODE_CHASE |-> $onehot0(led_levels))
        else $error("more than one LED lit in chase mode");

    // pairs mode shows one pair or nothing
    a_pairs_group: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && active_mode == lbps_pkg::MODE_PAIRS |->
            led_levels == '0 || led_levels == lbps_pkg::PAIR_LOW ||
            led_levels == lbps_pkg::PAIR_HIGH)
        else $error("bad LED group in pairs mode");

    // all mode flashes every LED together
    a_all_group: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && active_mode == lbps_pkg::MODE_ALL |->
            led_levels == '0 || led_levels == lbps_pkg::ALL_LEDS)
        else $error("partial LED group in all mode");

endmodule

bind led_buzzer_pattern_sequencer lbps_checker u_lbps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .led_levels  (rsp.led_levels),
    .active_mode (rsp.active_mode)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lbps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int REG_COUNT   = 8;
    localparam int LED_TMR     = 0;
    localparam int BEEP_TMR    = 1;
    localparam int MAX_LINES   = 100;

    typedef logic [LEN_W-1:0] reg_set_t [REG_COUNT];

    typedef struct {
        logic [TIME_W-1:0] start;
        logic [LEN_W-1:0]  length;
        bit                running;
    } one_shot_t;

    // one directed row: stamp, request, config reload first, fixed expectation
    typedef struct {
        logic [TIME_W-1:0] stamp;
        logic [MODE_W-1:0] mode;
        bit                reload;
        bit                pinned;
        result_t           want;
    } drive_row_t;

    localparam result_t NO_RESULT = '0;

    logic clk;
    logic rst_n;

    lbps_req_if req_ch();
    lbps_rsp_if rsp_ch();
    lbps_cfg_if cfg_ch();

    led_buzzer_pattern_sequencer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // sequencer mirror: settings and state as they stand after reset
    cfg_t live_cfg = '{RST_LED_ON_TIME, RST_LED_OFF_TIME, RST_START_BEEP_ENABLE,
                       RST_START_BEEP_TIME, RST_PAIR_BEEP_ON_TIME, RST_PAIR_BEEP_OFF_TIME,
                       RST_ALL_BEEP_ON_TIME, RST_ALL_BEEP_OFF_TIME};
    mode_t            cur_mode    = MODE_OFF;
    bit               seq_started = 1'b0;
    logic [1:0]       step_idx    = 2'd0;
    bit               lit         = 1'b0;
    bit               beep        = 1'b0;
    logic [LED_N-1:0] pins        = '0;
    one_shot_t        tmr [2]     = '{'{'0, '0, 1'b0}, '{'0, '0, 1'b0}};

    result_t levels_due [$];
    bit      pinned_valid;
    result_t pinned_result;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    drive_row_t plan [25] = '{
        '{32'd0,          8'h00, 1'b0, 1'b1, '{4'h0, 1'b0, MODE_OFF}},
        '{32'hFFFF_FFFF,  8'hFF, 1'b0, 1'b1, '{4'h0, 1'b0, MODE_OFF}},
        '{32'd5,          8'h04, 1'b0, 1'b1, '{4'h0, 1'b0, MODE_OFF}},
        '{32'd1000,       8'h01, 1'b0, 1'b1, '{4'h0, 1'b0, MODE_CHASE}},
        '{32'd1000,       8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd1250,       8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd1500,       8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd1750,       8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd2000,       8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd2500,       8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd3000,       8'h02, 1'b0, 1'b1, '{4'h0, 1'b0, MODE_PAIRS}},
        '{32'd3001,       8'h02, 1'b0, 1'b0, NO_RESULT},
        '{32'd3200,       8'h02, 1'b0, 1'b0, NO_RESULT},
        '{32'd3251,       8'h02, 1'b0, 1'b0, NO_RESULT},
        '{32'd4001,       8'h02, 1'b0, 1'b0, NO_RESULT},
        '{32'hFFFF_FFC0,  8'h03, 1'b0, 1'b1, '{4'h0, 1'b0, MODE_ALL}},
        '{32'hFFFF_FFC0,  8'h03, 1'b0, 1'b0, NO_RESULT},
        '{32'h0000_0010,  8'h03, 1'b0, 1'b0, NO_RESULT},
        // zero lengths with the entry beep on from here
        '{32'd7,          8'h00, 1'b1, 1'b1, '{4'h0, 1'b1, MODE_OFF}},
        '{32'd9,          8'hC8, 1'b0, 1'b1, '{4'h0, 1'b1, MODE_OFF}},
        '{32'd9,          8'h01, 1'b0, 1'b1, '{4'h0, 1'b1, MODE_CHASE}},
        '{32'd10,         8'h01, 1'b0, 1'b0, NO_RESULT},
        '{32'd10,         8'h02, 1'b0, 1'b1, '{4'h0, 1'b1, MODE_PAIRS}},
        '{32'd11,         8'h02, 1'b0, 1'b0, NO_RESULT},
        '{32'd11,         8'h03, 1'b0, 1'b1, '{4'h0, 1'b1, MODE_ALL}}
    };

    // timer helpers, elapsed time wraps at 2^32
    function automatic void arm_tmr(int k, logic [TIME_W-1:0] now, logic [LEN_W-1:0] len);
        tmr[k].start   = now;
        tmr[k].length  = len;
        tmr[k].running = 1'b1;
    endfunction

    function automatic bit tmr_fired(int k, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - tmr[k].start;
        if (tmr[k].running && elapsed >= {{(TIME_W-LEN_W){1'b0}}, tmr[k].length})
        begin
            tmr[k].running = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [LED_N-1:0] chase_led();
        return 4'b0001 << step_idx;
    endfunction

    function automatic logic [LED_N-1:0] pair_group();
        return (step_idx == 2'd0) ? PAIR_LOW : PAIR_HIGH;
    endfunction

    // buzzer on/off rhythm shared by pairs and all modes
    function automatic void step_buzzer(logic [TIME_W-1:0] now, logic [LEN_W-1:0] on_len,
                                        logic [LEN_W-1:0] off_len);
        if (!tmr[BEEP_TMR].running && !beep)
        begin
            beep = 1'b1;
            arm_tmr(BEEP_TMR, now, on_len);
        end
        if (tmr_fired(BEEP_TMR, now))
        begin
            beep = !beep;
            arm_tmr(BEEP_TMR, now, beep ? on_len : off_len);
        end
    endfunction

    function automatic void step_chase(logic [TIME_W-1:0] now);
        if (lit)
            pins |= chase_led();
        if (tmr_fired(LED_TMR, now))
        begin
            if (lit)
            begin
                pins &= ~chase_led();
                lit = 1'b0;
                arm_tmr(LED_TMR, now, live_cfg.led_off_time);
            end
            else
            begin
                step_idx = step_idx + 2'd1;
                pins |= chase_led();
                lit = 1'b1;
                arm_tmr(LED_TMR, now, live_cfg.led_on_time);
            end
        end
    endfunction

    function automatic void step_pairs(logic [TIME_W-1:0] now);
        // a step left over from chase mode folds back to the low pair
        if (step_idx > 2'd1)
            step_idx = 2'd0;
        if (lit)
            pins |= pair_group();
        if (tmr_fired(LED_TMR, now))
        begin
            if (lit)
            begin
                pins &= ~pair_group();
                lit = 1'b0;
                arm_tmr(LED_TMR, now, live_cfg.led_off_time);
            end
            else
            begin
                step_idx = (step_idx == 2'd0) ? 2'd1 : 2'd0;
                pins |= pair_group();
                lit = 1'b1;
                arm_tmr(LED_TMR, now, live_cfg.led_on_time);
            end
        end
        step_buzzer(now, live_cfg.pair_beep_on_time, live_cfg.pair_beep_off_time);
    endfunction

    function automatic void step_all(logic [TIME_W-1:0] now);
        if (lit)
            pins = ALL_LEDS;
        if (tmr_fired(LED_TMR, now))
        begin
            lit = !lit;
            pins = lit ? ALL_LEDS : '0;
            arm_tmr(LED_TMR, now, lit ? live_cfg.led_on_time : live_cfg.led_off_time);
        end
        step_buzzer(now, live_cfg.all_beep_on_time, live_cfg.all_beep_off_time);
    endfunction

    // mode entry: all dark, timers stopped, then arm for the new mode
    function automatic void switch_mode(logic [TIME_W-1:0] now, mode_t m);
        pins = '0;
        beep = 1'b0;
        lit = 1'b0;
        tmr[LED_TMR].running = 1'b0;
        tmr[BEEP_TMR].running = 1'b0;
        cur_mode = m;
        if (m != MODE_OFF)
        begin
            lit = 1'b1;
            arm_tmr(LED_TMR, now, live_cfg.led_on_time);
        end
        if (live_cfg.start_beep_enable)
        begin
            beep = 1'b1;
            arm_tmr(BEEP_TMR, now, live_cfg.start_beep_time);
        end
        seq_started = 1'b1;
    endfunction

    // advance the mirror by one tick and return the LED, buzzer and mode levels it leaves
    function automatic result_t sequence_step(logic [TIME_W-1:0] now,
                                              logic [MODE_W-1:0] req_mode);
        mode_t   m;
        result_t r;
        m = (req_mode >= MODE_COUNT) ? MODE_OFF : mode_t'(req_mode[1:0]);
        if (!seq_started || m != cur_mode)
            switch_mode(now, m);
        else
            case (cur_mode)
                MODE_CHASE: step_chase(now);
                MODE_PAIRS: step_pairs(now);
                MODE_ALL:   step_all(now);
                default:    ;
            endcase
        r.led_levels   = pins;
        r.buzzer_level = beep;
        r.active_mode  = cur_mode;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
        if (mismatch_count < MAX_LINES)
            $display("mismatch: %s got %0h expected %0h at %0t", what, seen, wanted, $time);
        mismatch_count++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // check returned items, then record the expectation for each accepted request
    always @(posedge clk)
    begin : watch
        result_t want;
        result_t mirror;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (levels_due.size() == 0)
                flag_mismatch("item with nothing expected", 32'(rsp_ch.led_levels), 32'd0);
            else
            begin
                want = levels_due.pop_front();
                if (rsp_ch.led_levels !== want.led_levels)
                    flag_mismatch("led_levels", 32'(rsp_ch.led_levels),
                                  32'(want.led_levels));
                if (rsp_ch.buzzer_level !== want.buzzer_level)
                    flag_mismatch("buzzer_level", 32'(rsp_ch.buzzer_level),
                                  32'(want.buzzer_level));
                if (rsp_ch.active_mode !== want.active_mode)
                    flag_mismatch("active_mode", 32'(rsp_ch.active_mode),
                                  32'(want.active_mode));
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            mirror = sequence_step(req_ch.time_ms, req_ch.mode_request);
            levels_due.push_back(pinned_valid ? pinned_result : mirror);
        end
    end

    // present one request and hold it until taken
    task automatic send_req(input logic [TIME_W-1:0] stamp, input logic [MODE_W-1:0] mode_in,
                            input bit pinned, input result_t pinned_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.time_ms      <= stamp;
        req_ch.mode_request <= mode_in;
        pinned_valid        <= pinned;
        pinned_result       <= pinned_res;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [LEN_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_LED_ON_TIME:        live_cfg.led_on_time        = value;
            REG_LED_OFF_TIME:       live_cfg.led_off_time       = value;
            REG_START_BEEP_ENABLE:  live_cfg.start_beep_enable  = value[0];
            REG_START_BEEP_TIME:    live_cfg.start_beep_time    = value;
            REG_PAIR_BEEP_ON_TIME:  live_cfg.pair_beep_on_time  = value;
            REG_PAIR_BEEP_OFF_TIME: live_cfg.pair_beep_off_time = value;
            REG_ALL_BEEP_ON_TIME:   live_cfg.all_beep_on_time   = value;
            REG_ALL_BEEP_OFF_TIME:  live_cfg.all_beep_off_time  = value;
            default:                ;
        endcase
    endtask

    task automatic load_settings(input reg_set_t vals);
        for (int k = 0; k < REG_COUNT; k++)
            write_reg(reg_idx_t'(k), vals[k]);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending and let every outstanding item come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        // wait so the last accepted request is already queued
        @(posedge clk);
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        reg_set_t          vals;
        logic [TIME_W-1:0] stamp;
        logic [MODE_W-1:0] mode_sel;
        int                run_left;
        int                span;

        req_ch.valid        = 1'b0;
        req_ch.time_ms      = '0;
        req_ch.mode_request = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        pinned_valid        = 1'b0;
        pinned_result       = NO_RESULT;
        rst_n               = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at reset settings, later with zero lengths and entry beep
        foreach (plan[i])
        begin
            if (plan[i].reload)
            begin
                settle();
                foreach (vals[k])
                    vals[k] = '0;
                vals[REG_START_BEEP_ENABLE] = 16'd1;
                load_settings(vals);
            end
            send_req(plan[i].stamp, plan[i].mode, plan[i].pinned, plan[i].want);
        end
        settle();

        // random phases: settings and idling change between phases
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 71; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            span = 0;
            foreach (vals[k])
            begin
                case (phase)
                    0:       vals[k] = 16'hFFFF;
                    1:       vals[k] = 16'h0000;
                    default:
                        case ($urandom_range(0, 3))
                            0:       vals[k] = 16'($urandom_range(0, 3));
                            1:       vals[k] = 16'($urandom_range(0, 60));
                            2:       vals[k] = 16'($urandom_range(0, 1500));
                            default: vals[k] = 16'($urandom_range(0, 65535));
                        endcase
                endcase
                if (k != REG_START_BEEP_ENABLE && int'(vals[k]) > span)
                    span = int'(vals[k]);
            end
            span = span / 2 + 8;
            load_settings(vals);

            stamp = $urandom;
            run_left = 0;
            mode_sel = '0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold a mode for a run of ticks, now and then an odd request
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 99) < 85)
                        mode_sel = 8'($urandom_range(0, 3));
                    else
                        mode_sel = 8'($urandom_range(4, 255));
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                case ($urandom_range(0, 15))
                    0:       stamp = $urandom;
                    1:       stamp = stamp + $urandom_range(65000, 70000);
                    2, 3, 4: stamp = stamp + $urandom_range(0, 2);
                    default: stamp = stamp + $urandom_range(0, span);
                endcase
                send_req(stamp, mode_sel, 1'b0, NO_RESULT);
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
